// ===== rtl/quadrature_angle_pid_motor_drive_assert.svh =====
// Assertion macros for the quadrature angle PID motor drive.
// Included by the top level; depends on nothing else.
`ifndef QUADRATURE_ANGLE_PID_MOTOR_DRIVE_ASSERT_SVH
`define QUADRATURE_ANGLE_PID_MOTOR_DRIVE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QAPD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QAPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/qapd_pkg.sv =====
// Shared types, constants and width helpers for the quadrature angle PID motor drive.
// No dependencies; used by qapd_track and the top level.
package qapd_pkg;

  localparam int GAIN_W     = 16;
  localparam int SETPOINT_W = 11;
  localparam int DUTY_W     = 7;
  localparam int DUTY_MAX   = 100;
  localparam int FRAC_BITS  = 8;
  localparam int RECIP_SHIFT = 24;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int IN_TDATA_W = 8;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd3328;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd1024;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd256;

  typedef enum logic [1:0] {
    REG_PROP_GAIN  = 2'd0,
    REG_INTEG_GAIN = 2'd1,
    REG_DERIV_GAIN = 2'd2,
    REG_SETPOINT   = 2'd3
  } reg_idx_t;

  // Width of the signed angle count: holds +/-(half + 2) before wrapping.
  function automatic int count_width(input int half);
    return $clog2(half + 3) + 1;
  endfunction

  // Width of the signed error setpoint - count.
  function automatic int err_width(input int cw);
    return ((cw > SETPOINT_W) ? cw : SETPOINT_W) + 1;
  endfunction

endpackage

// ===== rtl/quadrature_angle_pid_motor_drive.sv =====
// Top level of the quadrature angle PID motor drive: APB register file and drive pipeline.
// Depends on qapd_pkg, qapd_track and quadrature_angle_pid_motor_drive_assert.svh.
//
// Usage: each input transaction on s_tvalid/s_tready/s_tdata carries one sample of the
// encoder phases (phase_a in bit 0, phase_b in bit 1). Every accepted sample produces
// exactly one output transaction on m_tvalid/m_tready/m_tdata with the direction pins,
// the PWM duty and the wrapped angle count after that sample.
// Throughput is one sample per clock cycle while the receiver keeps taking results. The
// angle counter and the error window update in the cycle a sample is accepted, so the
// next sample may follow immediately. From acceptance to m_tvalid a result passes the
// stages in order: decoding and the window update, the three gain multipliers, the
// weighted total and its saturation, and the reciprocal multiply that scales the
// magnitude into a duty value.
// Every pipeline stage has its own valid bit, so a stalled receiver only backs up the
// stages that are full; samples keep being taken while bubbles remain. With all four
// stages full, s_tready drops until the receiver takes a result.
// Reset clears the counter, the previous phase levels, the error window and its running
// sum, the pipeline valid bits, and restores the gains (13.0, 4.0, 1.0 in Q8.8) and a
// zero setpoint. Registers are written through APB at byte addresses 0, 4, 8 and 12.
// The user must write them only while the pipeline is idle; the block does not enforce it.
`include "quadrature_angle_pid_motor_drive_assert.svh"

module quadrature_angle_pid_motor_drive #(
  parameter int WINDOW_LEN      = 5,
  parameter int HALF_REV_COUNTS = 800,
  localparam int CW       = qapd_pkg::count_width(HALF_REV_COUNTS),
  localparam int OUT_W    = 2 + qapd_pkg::DUTY_W + CW,
  localparam int OUT_TW   = ((OUT_W + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [qapd_pkg::IN_TDATA_W-1:0]   s_tdata,  // [0] phase_a, [1] phase_b
  // Output stream.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] drive_fwd, [1] drive_rev, [8:2] duty, next CW bits angle_count, zero fill
  output logic [OUT_TW-1:0]                 m_tdata,
  // Register port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [qapd_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [qapd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [qapd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int EW   = qapd_pkg::err_width(CW);
  localparam int SW   = EW + $clog2(WINDOW_LEN);
  localparam int GW1  = qapd_pkg::GAIN_W + 1;
  localparam int PW   = GW1 + EW;
  localparam int DW   = GW1 + EW + 1;
  localparam int IW   = GW1 + SW;
  localparam int TW   = GW1 + EW + $clog2(WINDOW_LEN) + 4;
  localparam int MW   = TW - qapd_pkg::FRAC_BITS;
  localparam int QMAX = (qapd_pkg::DUTY_MAX + 1) * WINDOW_LEN - 1;
  localparam int QW   = $clog2(QMAX + 1);
  localparam int RECIP_VAL = ((2 ** qapd_pkg::RECIP_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int RW   = qapd_pkg::RECIP_SHIFT + 1;
  localparam logic [RW-1:0]          RECIP  = RW'(RECIP_VAL);
  localparam logic signed [TW-1:0]   WL_S   = TW'(WINDOW_LEN);
  localparam logic signed [CW-1:0]   HALF_S = CW'(HALF_REV_COUNTS);

  // ---------------------------------------------------------------------------
  // Register file. Writes land on the access phase; reads are combinational.
  // ---------------------------------------------------------------------------
  logic [qapd_pkg::GAIN_W-1:0]          prop_gain;
  logic [qapd_pkg::GAIN_W-1:0]          integ_gain;
  logic [qapd_pkg::GAIN_W-1:0]          deriv_gain;
  logic signed [qapd_pkg::SETPOINT_W-1:0] setpoint;
  qapd_pkg::reg_idx_t                   reg_idx;
  logic                                 reg_write;

  assign pready    = 1'b1;
  assign reg_idx   = qapd_pkg::reg_idx_t'(paddr[3:2]);
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= qapd_pkg::PROP_GAIN_RST;
      integ_gain <= qapd_pkg::INTEG_GAIN_RST;
      deriv_gain <= qapd_pkg::DERIV_GAIN_RST;
      setpoint   <= '0;
    end else if (reg_write) begin
      unique case (reg_idx)
        qapd_pkg::REG_PROP_GAIN:  prop_gain  <= pwdata[qapd_pkg::GAIN_W-1:0];
        qapd_pkg::REG_INTEG_GAIN: integ_gain <= pwdata[qapd_pkg::GAIN_W-1:0];
        qapd_pkg::REG_DERIV_GAIN: deriv_gain <= pwdata[qapd_pkg::GAIN_W-1:0];
        qapd_pkg::REG_SETPOINT:   setpoint   <= pwdata[qapd_pkg::SETPOINT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      qapd_pkg::REG_PROP_GAIN:  prdata = qapd_pkg::APB_DATA_W'(prop_gain);
      qapd_pkg::REG_INTEG_GAIN: prdata = qapd_pkg::APB_DATA_W'(integ_gain);
      qapd_pkg::REG_DERIV_GAIN: prdata = qapd_pkg::APB_DATA_W'(deriv_gain);
      qapd_pkg::REG_SETPOINT:   prdata = qapd_pkg::APB_DATA_W'(setpoint);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage may load when it is empty or its
  // successor is loading too.
  // ---------------------------------------------------------------------------
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy_o;
  logic accept;

  assign rdy_o    = !m_tvalid || m_tready;
  assign rdy3     = !v3 || rdy_o;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (rdy1)  v1       <= s_tvalid;
      if (rdy2)  v2       <= v1;
      if (rdy3)  v3       <= v2;
      if (rdy_o) m_tvalid <= v3;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: decoder, counter and error window (state updates on acceptance).
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] trk_count;
  logic signed [EW-1:0] trk_err;
  logic signed [EW:0]   trk_diff;
  logic signed [SW-1:0] trk_sum;

  qapd_track #(
    .WINDOW_LEN      (WINDOW_LEN),
    .HALF_REV_COUNTS (HALF_REV_COUNTS)
  ) u_track (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .phase_a    (s_tdata[0]),
    .phase_b    (s_tdata[1]),
    .setpoint   (setpoint),
    .count_next (trk_count),
    .err        (trk_err),
    .diff       (trk_diff),
    .sum_next   (trk_sum)
  );

  logic signed [CW-1:0] s1_count;
  logic signed [EW-1:0] s1_err;
  logic signed [EW:0]   s1_diff;
  logic signed [SW-1:0] s1_sum;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_count <= trk_count;
      s1_err   <= trk_err;
      s1_diff  <= trk_diff;
      s1_sum   <= trk_sum;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the three gain products. Gains are unsigned, so they get a zero
  // sign bit before the signed multiply.
  // ---------------------------------------------------------------------------
  logic signed [GW1-1:0] kp_s, ki_s, kd_s;
  logic signed [PW-1:0]  p_next;
  logic signed [DW-1:0]  d_next;
  logic signed [IW-1:0]  i_next;
  logic signed [PW-1:0]  s2_p;
  logic signed [DW-1:0]  s2_d;
  logic signed [IW-1:0]  s2_i;
  logic signed [CW-1:0]  s2_count;

  assign kp_s   = {1'b0, prop_gain};
  assign ki_s   = {1'b0, integ_gain};
  assign kd_s   = {1'b0, deriv_gain};
  assign p_next = kp_s * s1_err;
  assign d_next = kd_s * s1_diff;
  assign i_next = ki_s * s1_sum;

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      s2_p     <= p_next;
      s2_d     <= d_next;
      s2_i     <= i_next;
      s2_count <= s1_count;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: total in units of 1/(256*WINDOW_LEN), its sign, and the magnitude
  // with the fraction dropped, clamped so the final quotient never exceeds 100.
  // ---------------------------------------------------------------------------
  logic signed [TW-1:0] pd_sum;
  logic signed [TW-1:0] total;
  logic [TW-1:0]        mag;
  logic [MW-1:0]        q_full;
  logic [QW-1:0]        q_sat;
  logic                 s3_fwd, s3_rev;
  logic [QW-1:0]        s3_q;
  logic signed [CW-1:0] s3_count;

  always_comb begin
    pd_sum = TW'(s2_p) + TW'(s2_d);
    total  = pd_sum * WL_S + TW'(s2_i);
    mag    = total[TW-1] ? TW'(-total) : TW'(total);
    q_full = mag[TW-1:qapd_pkg::FRAC_BITS];
    q_sat  = (q_full > MW'(QMAX)) ? QW'(QMAX) : q_full[QW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      s3_fwd   <= !total[TW-1] && (total != '0);
      s3_rev   <= total[TW-1];
      s3_q     <= q_sat;
      s3_count <= s2_count;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: divide by WINDOW_LEN through a rounded-up reciprocal; exact for
  // every clamped magnitude, so no correction step follows.
  // ---------------------------------------------------------------------------
  logic [QW+RW-1:0]              q_prod;
  logic                          o_fwd, o_rev;
  logic [qapd_pkg::DUTY_W-1:0]   o_duty;
  logic signed [CW-1:0]          o_count;

  assign q_prod = (QW+RW)'(s3_q) * (QW+RW)'(RECIP);

  always_ff @(posedge clk) begin
    if (rdy_o && v3) begin
      o_fwd   <= s3_fwd;
      o_rev   <= s3_rev;
      o_duty  <= q_prod[qapd_pkg::RECIP_SHIFT +: qapd_pkg::DUTY_W];
      o_count <= s3_count;
    end
  end

  assign m_tdata = OUT_TW'({o_count, o_duty, o_rev, o_fwd});

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `QAPD_ASSERT_SAME(a_duty_dir, clk, rst, m_tvalid, (o_duty <= qapd_pkg::DUTY_W'(qapd_pkg::DUTY_MAX)) && !(o_fwd && o_rev), "duty above limit or both direction pins set")
  `QAPD_ASSERT_SAME(a_zero_drive, clk, rst, m_tvalid && !o_fwd && !o_rev, o_duty == '0, "zero drive with nonzero duty")
  `QAPD_ASSERT_SAME(a_count_range, clk, rst, v1, (s1_count <= HALF_S) && (s1_count >= -HALF_S), "angle count outside the wrap range")
  `QAPD_ASSERT_NEXT(a_accept_fills, clk, rst, accept, v1, "accepted sample did not enter the pipeline")

endmodule

// ===== rtl/qapd_track.sv =====
// Quadrature decoder, wrapped angle counter and shifting error window with a running sum.
// Depends on qapd_pkg for width helpers.
module qapd_track #(
  parameter int WINDOW_LEN      = 5,
  parameter int HALF_REV_COUNTS = 800,
  localparam int CW = qapd_pkg::count_width(HALF_REV_COUNTS),
  localparam int EW = qapd_pkg::err_width(CW),
  localparam int SW = EW + $clog2(WINDOW_LEN)
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  accept,
  input  logic                                  phase_a,
  input  logic                                  phase_b,
  input  logic signed [qapd_pkg::SETPOINT_W-1:0] setpoint,
  output logic signed [CW-1:0]                  count_next,
  output logic signed [EW-1:0]                  err,
  output logic signed [EW:0]                    diff,
  output logic signed [SW-1:0]                  sum_next
);

  localparam logic signed [CW:0] HALF = (CW+1)'(HALF_REV_COUNTS);
  localparam logic signed [CW:0] FULL = (CW+1)'(2 * HALF_REV_COUNTS);

  logic signed [CW-1:0] count;
  logic                 prev_a;
  logic                 prev_b;
  logic signed [EW-1:0] win [WINDOW_LEN];
  logic signed [SW-1:0] sum;

  logic signed [CW:0] step_a;
  logic signed [CW:0] step_b;
  logic signed [CW:0] raw;
  logic signed [CW:0] wrapped;
  logic               shift;

  always_comb begin
    step_a = '0;
    if (phase_a != prev_a) begin
      step_a = (phase_b != phase_a) ? (CW+1)'(1) : -(CW+1)'(1);
    end
    step_b = '0;
    if (phase_b != prev_b) begin
      step_b = (phase_a == phase_b) ? (CW+1)'(1) : -(CW+1)'(1);
    end
    raw = (CW+1)'(count) + step_a + step_b;
    if (raw > HALF) begin
      wrapped = raw - FULL;
    end else if (raw < -HALF) begin
      wrapped = raw + FULL;
    end else begin
      wrapped = raw;
    end
    count_next = wrapped[CW-1:0];
    err        = EW'(setpoint) - EW'(count_next);
    // The window only moves when the error differs from its second-to-last entry;
    // otherwise the derivative term is zero.
    shift      = (err != win[WINDOW_LEN-2]);
    diff       = shift ? ((EW+1)'(err) - (EW+1)'(win[WINDOW_LEN-1])) : '0;
    sum_next   = shift ? (sum - SW'(win[0]) + SW'(err)) : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      prev_a <= 1'b0;
      prev_b <= 1'b0;
      sum    <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win[i] <= '0;
      end
    end else if (accept) begin
      count  <= count_next;
      prev_a <= phase_a;
      prev_b <= phase_b;
      if (shift) begin
        sum <= sum_next;
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          win[i] <= win[i+1];
        end
        win[WINDOW_LEN-1] <= err;
      end
    end
  end

endmodule
